### src/npd_pkg.sv
// Shared types, codes and helper functions of the netpbm stream decoder.
package npd_pkg;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_UNKNOWN  = 3'd1;
  localparam logic [2:0] STAT_CORRUPT  = 3'd2;
  localparam logic [2:0] STAT_MISMATCH = 3'd3;
  localparam logic [2:0] STAT_TRUNC    = 3'd4;

  localparam logic [2:0] PH_MAGIC0 = 3'd0;
  localparam logic [2:0] PH_MAGIC1 = 3'd1;
  localparam logic [2:0] PH_WIDTH  = 3'd2;
  localparam logic [2:0] PH_HEIGHT = 3'd3;
  localparam logic [2:0] PH_MAXV   = 3'd4;
  localparam logic [2:0] PH_PIXELS = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  localparam logic [31:0] COLOR_WHITE = 32'hffffffff;
  localparam logic [31:0] COLOR_BLACK = 32'hff000000;
  localparam logic [19:0] NUM_LIMIT   = 20'd65535;
  localparam logic [15:0] RAW_WIDE    = 16'd256;

  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_NL   = 8'h0a;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  typedef struct packed {
    logic [7:0] value;
    logic       sof;
    logic       eof;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_hash;
    logic       is_nl;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] color;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  status;
    logic        last;
  } result_t;

  function automatic cmd_t classify(logic [7:0] b, logic sof, logic eof);
    cmd_t c;
    c.value    = b;
    c.sof      = sof;
    c.eof      = eof;
    c.is_digit = (b >= CHAR_0) && (b <= CHAR_9);
    c.digit    = b[3:0];
    c.is_hash  = (b == CHAR_HASH);
    c.is_nl    = (b == CHAR_NL);
    return c;
  endfunction

  function automatic result_t mk_status(logic [2:0] st);
    result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    return r;
  endfunction

  function automatic result_t mk_pixel(logic [31:0] color, logic last);
    result_t r;
    r = '0;
    r.kind = KIND_PIXEL;
    r.color = color;
    r.last = last;
    return r;
  endfunction

  function automatic result_t mk_header(logic [15:0] w, logic [15:0] h);
    result_t r;
    r = '0;
    r.kind = KIND_HEADER;
    r.width = w;
    r.height = h;
    return r;
  endfunction

endpackage

### src/npd_fifo.sv
// Small first-in first-out queue of register entries.
module npd_fifo #(
  parameter int WIDTH      = 8,
  parameter int DEPTH_LOG2 = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wptr;
  logic [DEPTH_LOG2-1:0] rptr;
  logic [DEPTH_LOG2:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (DEPTH_LOG2 + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

### src/npd_front.sv
// Input side: takes file bytes, classifies them and queues them for the parser.
module npd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    byte_value,
  input  logic          start_of_file,
  input  logic          end_of_file,
  input  logic          push,
  output logic          full,
  output logic          cmd_valid,
  output npd_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import npd_pkg::*;

  cmd_t cmd_in;
  logic q_empty;

  assign cmd_in    = classify(byte_value, start_of_file, end_of_file);
  assign cmd_valid = !q_empty;

  npd_fifo #(.WIDTH($bits(cmd_t)), .DEPTH_LOG2(2)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (q_empty)
  );
endmodule

### src/npd_div.sv
// Sample scaler: computes min(floor(v*255/max), 255) by restoring division.
module npd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] v,
  input  logic [15:0] max_value,
  output logic        busy,
  output logic        done,
  output logic [7:0]  q
);
  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_LOAD = 3'b010,
    DV_RUN  = 3'b100
  } dv_state_t;

  dv_state_t   dv_state;
  logic [23:0] num;
  logic [15:0] maxr;
  logic [15:0] rem;
  logic [2:0]  cnt;
  logic [16:0] trial;
  logic        take;

  assign busy  = (dv_state != DV_IDLE);
  assign trial = {rem, num[23]};
  assign take  = (trial >= {1'b0, maxr});

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_state <= DV_IDLE;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (dv_state)
        DV_IDLE: begin
          if (start) begin
            num      <= {v, 8'd0} - {8'd0, v};
            maxr     <= max_value;
            dv_state <= DV_LOAD;
          end
        end
        DV_LOAD: begin
          // The quotient saturates when the upper part alone reaches the divisor.
          if (num[23:8] >= maxr) begin
            q        <= 8'hff;
            done     <= 1'b1;
            dv_state <= DV_IDLE;
          end else begin
            rem      <= num[23:8];
            num      <= {num[7:0], 16'd0};
            cnt      <= 3'd7;
            dv_state <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem <= take ? 16'(trial - {1'b0, maxr}) : trial[15:0];
          q   <= {q[6:0], take};
          num <= {num[22:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == 3'd0) begin
            done     <= 1'b1;
            dv_state <= DV_IDLE;
          end
        end
        default: dv_state <= DV_IDLE;
      endcase
    end
  end
endmodule

### src/npd_back.sv
// Parser sequencer: works through one queued byte at a time and emits results.
module npd_back #(
  parameter int DIM_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      expected_width,
  input  logic [15:0]      expected_height,
  input  logic             cmd_valid,
  input  npd_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_push,
  output npd_pkg::result_t res,
  input  logic             res_full
);
  import npd_pkg::*;

  typedef enum logic [10:0] {
    ST_FETCH    = 11'b00000000001,
    ST_DISPATCH = 11'b00000000010,
    ST_NUM      = 11'b00000000100,
    ST_HDR      = 11'b00000001000,
    ST_DIVST    = 11'b00000010000,
    ST_DIVW     = 11'b00000100000,
    ST_PIX      = 11'b00001000000,
    ST_ENDST    = 11'b00010000000,
    ST_POST     = 11'b00100000000,
    ST_BITS     = 11'b01000000000,
    ST_EOF      = 11'b10000000000
  } state_t;

  // Separate state for the final flush of a byte's held result.
  logic flush;

  typedef enum logic [2:0] {
    MODE_MAGIC0,
    MODE_MAGIC1,
    MODE_TEXT,
    MODE_BW,
    MODE_BITS,
    MODE_RAW,
    MODE_NONE
  } mode_t;

  typedef enum logic [1:0] {
    CTX_PLAIN,
    CTX_TEXT,
    CTX_BITS
  } ctx_t;

  state_t      state;
  mode_t       mode;
  ctx_t        ctx;
  cmd_t        cur;
  logic [2:0]  phase;
  logic [2:0]  fmt;
  logic        comment;
  logic        numact;
  logic [15:0] accum;
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic [15:0] max_reg;
  logic [31:0] pixels_left;
  logic [15:0] column_count;
  logic [1:0]  comp;
  logic [7:0]  red_hold;
  logic [7:0]  green_hold;
  logic [7:0]  high_hold;
  logic        byte_phase;
  logic        before_pix;
  logic [2:0]  bit_idx;
  logic [31:0] pix_color;
  logic [15:0] sample_v;
  result_t     pend;
  logic        pend_valid;

  result_t     emit_data;
  logic        emit_req;
  logic        emit_ok;
  logic        go;
  logic [15:0] acc_base;
  logic [19:0] acc_next;
  logic        acc_over;
  logic        dim_bad;
  logic        type_ok;
  logic        mismatch;
  logic        raw_wide;
  logic        div_busy;
  logic        div_done;
  logic [7:0]  div_q;
  logic [15:0] col_inc;

  assign acc_base = numact ? accum : 16'd0;
  assign acc_next = {1'b0, acc_base, 3'd0} + {3'd0, acc_base, 1'b0} + {16'd0, cur.digit};
  assign acc_over = (acc_next > NUM_LIMIT);
  assign dim_bad  = (accum == 16'd0) || (({16'd0, accum} >> DIM_BITS) != 32'd0);
  assign type_ok  = cur.is_digit && (cur.digit >= 4'd1) && (cur.digit <= 4'd6);
  assign mismatch = ((expected_width != 16'd0) && (expected_width != width_reg)) ||
                    ((expected_height != 16'd0) && (expected_height != height_reg));
  assign raw_wide = (max_reg >= RAW_WIDE);
  assign col_inc  = column_count + 16'd1;

  always_comb begin
    case (phase)
      PH_MAGIC0: mode = MODE_MAGIC0;
      PH_MAGIC1: mode = MODE_MAGIC1;
      PH_WIDTH, PH_HEIGHT, PH_MAXV: mode = MODE_TEXT;
      PH_PIXELS: begin
        case (fmt)
          3'd1:       mode = MODE_BW;
          3'd4:       mode = MODE_BITS;
          3'd5, 3'd6: mode = MODE_RAW;
          default:    mode = MODE_TEXT;
        endcase
      end
      default: mode = MODE_NONE;
    endcase
  end

  always_comb begin
    emit_req  = 1'b0;
    emit_data = mk_status(STAT_OK);
    case (state)
      ST_DISPATCH: begin
        case (mode)
          MODE_MAGIC0: begin
            if (cur.value != CHAR_P) begin
              emit_req  = 1'b1;
              emit_data = mk_status(STAT_UNKNOWN);
            end
          end
          MODE_MAGIC1: begin
            if (!type_ok) begin
              emit_req  = 1'b1;
              emit_data = mk_status(STAT_UNKNOWN);
            end
          end
          MODE_TEXT: begin
            if (!comment && cur.is_digit && acc_over) begin
              emit_req  = 1'b1;
              emit_data = mk_status(STAT_CORRUPT);
            end
          end
          default: ;
        endcase
      end
      ST_NUM: begin
        case (phase)
          PH_WIDTH, PH_HEIGHT: begin
            if (dim_bad) begin
              emit_req  = 1'b1;
              emit_data = mk_status(STAT_CORRUPT);
            end
          end
          PH_MAXV: begin
            if (accum == 16'd0) begin
              emit_req  = 1'b1;
              emit_data = mk_status(STAT_UNKNOWN);
            end
          end
          default: ;
        endcase
      end
      ST_HDR: begin
        emit_req  = 1'b1;
        emit_data = mismatch ? mk_status(STAT_MISMATCH) : mk_header(width_reg, height_reg);
      end
      ST_PIX: begin
        emit_req  = 1'b1;
        emit_data = mk_pixel(pix_color, pixels_left == 32'd1);
      end
      ST_ENDST: begin
        emit_req  = 1'b1;
        emit_data = mk_status(STAT_OK);
      end
      ST_EOF: begin
        if (cur.eof && (phase != PH_DONE) && !(numact && !comment)) begin
          emit_req  = 1'b1;
          emit_data = mk_status(STAT_TRUNC);
        end
      end
      default: ;
    endcase
  end

  // A new result pushes out the held one; the held one is marked last at byte end.
  assign emit_ok  = !pend_valid || !res_full;
  assign go       = !emit_req || emit_ok;
  assign cmd_pop  = (state == ST_FETCH) && !flush && cmd_valid;
  assign res_push = pend_valid && !res_full && ((emit_req && !flush) || flush);

  always_comb begin
    res = pend;
    if (flush) begin
      res.last = 1'b1;
    end
  end

  npd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ST_DIVST),
    .v         (sample_v),
    .max_value (max_reg),
    .busy      (div_busy),
    .done      (div_done),
    .q         (div_q)
  );

  always_ff @(posedge clk) begin
    if (emit_req && emit_ok && !flush) begin
      pend <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FETCH;
      flush        <= 1'b0;
      pend_valid   <= 1'b0;
      phase        <= PH_MAGIC0;
      fmt          <= 3'd0;
      comment      <= 1'b0;
      numact       <= 1'b0;
      accum        <= 16'd0;
      width_reg    <= 16'd0;
      height_reg   <= 16'd0;
      max_reg      <= 16'd0;
      pixels_left  <= 32'd0;
      column_count <= 16'd0;
      comp         <= 2'd0;
      red_hold     <= 8'd0;
      green_hold   <= 8'd0;
      high_hold    <= 8'd0;
      byte_phase   <= 1'b0;
    end else if (flush) begin
      if (!pend_valid) begin
        flush <= 1'b0;
      end else if (!res_full) begin
        pend_valid <= 1'b0;
        flush      <= 1'b0;
      end
    end else if (go) begin
      if (emit_req) begin
        pend_valid <= 1'b1;
      end
      case (state)
        ST_FETCH: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= ST_DISPATCH;
            if (cmd.sof) begin
              phase        <= PH_MAGIC0;
              fmt          <= 3'd0;
              comment      <= 1'b0;
              numact       <= 1'b0;
              accum        <= 16'd0;
              width_reg    <= 16'd0;
              height_reg   <= 16'd0;
              max_reg      <= 16'd0;
              pixels_left  <= 32'd0;
              column_count <= 16'd0;
              comp         <= 2'd0;
              red_hold     <= 8'd0;
              green_hold   <= 8'd0;
              high_hold    <= 8'd0;
              byte_phase   <= 1'b0;
            end
          end
        end
        ST_DISPATCH: begin
          state <= ST_EOF;
          case (mode)
            MODE_MAGIC0: begin
              phase <= (cur.value == CHAR_P) ? PH_MAGIC1 : PH_DONE;
            end
            MODE_MAGIC1: begin
              if (type_ok) begin
                fmt     <= cur.digit[2:0];
                comment <= 1'b0;
                numact  <= 1'b0;
                phase   <= PH_WIDTH;
              end else begin
                phase <= PH_DONE;
              end
            end
            MODE_TEXT: begin
              if (comment) begin
                if (cur.is_nl) begin
                  comment <= 1'b0;
                end
              end else if (cur.is_digit) begin
                if (acc_over) begin
                  numact <= 1'b0;
                  phase  <= PH_DONE;
                end else begin
                  numact <= 1'b1;
                  accum  <= acc_next[15:0];
                end
              end else if (numact) begin
                numact     <= 1'b0;
                ctx        <= CTX_TEXT;
                before_pix <= (phase == PH_PIXELS);
                state      <= ST_NUM;
              end else if (cur.is_hash) begin
                comment <= 1'b1;
              end
            end
            MODE_BW: begin
              if (comment) begin
                if (cur.is_nl) begin
                  comment <= 1'b0;
                end
              end else if (cur.is_digit) begin
                pix_color <= (cur.digit == 4'd0) ? COLOR_WHITE : COLOR_BLACK;
                ctx       <= CTX_PLAIN;
                state     <= ST_PIX;
              end else if (cur.is_hash) begin
                comment <= 1'b1;
              end
            end
            MODE_BITS: begin
              bit_idx <= 3'd7;
              state   <= ST_BITS;
            end
            MODE_RAW: begin
              if (raw_wide && !byte_phase) begin
                high_hold  <= cur.value;
                byte_phase <= 1'b1;
              end else begin
                byte_phase <= 1'b0;
                sample_v   <= raw_wide ? {high_hold, cur.value} : {8'd0, cur.value};
                ctx        <= CTX_PLAIN;
                state      <= ST_DIVST;
              end
            end
            default: ;
          endcase
        end
        ST_NUM: begin
          state <= ST_POST;
          case (phase)
            PH_WIDTH: begin
              if (dim_bad) begin
                phase <= PH_DONE;
              end else begin
                width_reg <= accum;
                phase     <= PH_HEIGHT;
              end
            end
            PH_HEIGHT: begin
              if (dim_bad) begin
                phase <= PH_DONE;
              end else begin
                height_reg <= accum;
                if ((fmt == 3'd1) || (fmt == 3'd4)) begin
                  state <= ST_HDR;
                end else begin
                  phase <= PH_MAXV;
                end
              end
            end
            PH_MAXV: begin
              if (accum == 16'd0) begin
                phase <= PH_DONE;
              end else begin
                max_reg <= accum;
                state   <= ST_HDR;
              end
            end
            PH_PIXELS: begin
              sample_v <= accum;
              state    <= ST_DIVST;
            end
            default: ;
          endcase
        end
        ST_HDR: begin
          state <= ST_POST;
          if (mismatch) begin
            phase <= PH_DONE;
          end else begin
            pixels_left  <= {16'd0, width_reg} * {16'd0, height_reg};
            column_count <= 16'd0;
            comp         <= 2'd0;
            byte_phase   <= 1'b0;
            comment      <= 1'b0;
            numact       <= 1'b0;
            phase        <= PH_PIXELS;
          end
        end
        ST_DIVST: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            if ((fmt == 3'd2) || (fmt == 3'd5)) begin
              pix_color <= {8'hff, div_q, div_q, div_q};
              state     <= ST_PIX;
            end else if (comp == 2'd0) begin
              red_hold <= div_q;
              comp     <= 2'd1;
              state    <= ST_POST;
            end else if (comp == 2'd1) begin
              green_hold <= div_q;
              comp       <= 2'd2;
              state      <= ST_POST;
            end else begin
              comp      <= 2'd0;
              pix_color <= {8'hff, red_hold, green_hold, div_q};
              state     <= ST_PIX;
            end
          end
        end
        ST_PIX: begin
          if (pixels_left != 32'd0) begin
            pixels_left <= pixels_left - 32'd1;
          end
          if (pixels_left <= 32'd1) begin
            phase <= PH_DONE;
            state <= ST_ENDST;
          end else begin
            state <= ST_POST;
          end
        end
        ST_ENDST: begin
          state <= ST_POST;
        end
        ST_POST: begin
          state <= ST_EOF;
          case (ctx)
            CTX_TEXT: begin
              // Raw formats swallow the byte that ends the header.
              if ((phase != PH_DONE) &&
                  !(!before_pix && (phase == PH_PIXELS) && (fmt >= 3'd4)) &&
                  cur.is_hash) begin
                comment <= 1'b1;
              end
            end
            CTX_BITS: begin
              if (phase == PH_PIXELS) begin
                if (col_inc >= width_reg) begin
                  column_count <= 16'd0;
                end else begin
                  column_count <= col_inc;
                  if (bit_idx != 3'd0) begin
                    bit_idx <= bit_idx - 3'd1;
                    state   <= ST_BITS;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        ST_BITS: begin
          pix_color <= cur.value[bit_idx] ? COLOR_BLACK : COLOR_WHITE;
          ctx       <= CTX_BITS;
          state     <= ST_PIX;
        end
        ST_EOF: begin
          state <= ST_FETCH;
          flush <= 1'b1;
          if (cur.eof && (phase != PH_DONE)) begin
            if (numact && !comment) begin
              numact <= 1'b0;
              ctx    <= CTX_PLAIN;
              state  <= ST_NUM;
              flush  <= 1'b0;
            end else begin
              phase <= PH_DONE;
            end
          end
        end
        default: state <= ST_FETCH;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into a full queue");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
      div_busy |-> (state == ST_DIVW))
    else $error("scaler busy outside the wait state");
  a_pixels_left: assert property (@(posedge clk) disable iff (rst)
      (phase == PH_PIXELS) |-> (pixels_left != 32'd0))
    else $error("pixel phase with no pixels left");
  a_fetch_clean: assert property (@(posedge clk) disable iff (rst)
      cmd_pop |-> !pend_valid)
    else $error("new byte taken while a result is still held");
endmodule

### src/netpbm_stream_decoder_top.sv
// Top level of the netpbm P1 to P6 stream decoder with its register port.
//
// Usage: file bytes enter on the push/full queue side, one item per byte,
// with start_of_file on the first byte and end_of_file on the last one.
// Results leave on the empty/pop side: pixels as ARGB words, one header
// item after the size is parsed, and status items for errors and image end.
// last_flag marks the final pixel and the final result caused by a byte.
// Two registers (expected width at address 0, height at address 4) are
// written over the APB-style port; the user must write them only while the
// decoder is idle, and the block itself does not enforce it. Each result
// waits in a holding register until the next result or the end of its byte.
// In the sequencer a byte passes the fetch, dispatch and end-of-file states.
// Completing a number, sample or pixel adds a post state, plus the number,
// header check, pixel and end status states and, for each scaled sample,
// the shared restoring divider, which stops early when it saturates.
// A P4 byte adds bit, pixel and post states for each pixel that it holds.
// Both sides have four-entry queues; when the receiver stalls, the result
// queue fills, the parser stops and then the input queue fills and full rises.
// Reset clears the control and header state of the parser and both registers; no clearing pass.
module netpbm_stream_decoder_top #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [7:0]  byte_value,
  input  logic        start_of_file,
  input  logic        end_of_file,
  input  logic        push,
  output logic        full,
  output logic [1:0]  result_kind,
  output logic [31:0] pixel_color,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [2:0]  status,
  output logic        last_flag,
  output logic        empty,
  input  logic        pop
);
  import npd_pkg::*;

  logic [15:0] expected_width;
  logic [15:0] expected_height;
  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_pop;
  logic        res_push;
  result_t     res_in;
  result_t     res_out;
  logic        res_full;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'd0, expected_height} : {16'd0, expected_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_width  <= 16'd0;
      expected_height <= 16'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        expected_height <= pwdata[15:0];
      end else begin
        expected_width <= pwdata[15:0];
      end
    end
  end

  npd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_value    (byte_value),
    .start_of_file (start_of_file),
    .end_of_file   (end_of_file),
    .push          (push),
    .full          (full),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  npd_back #(.DIM_BITS(DIM_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .expected_width  (expected_width),
    .expected_height (expected_height),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .res_push        (res_push),
    .res             (res_in),
    .res_full        (res_full)
  );

  npd_fifo #(.WIDTH($bits(result_t)), .DEPTH_LOG2(2)) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign result_kind  = res_out.kind;
  assign pixel_color  = res_out.color;
  assign image_width  = res_out.width;
  assign image_height = res_out.height;
  assign status       = res_out.status;
  assign last_flag    = res_out.last;
endmodule
